>>> rtl/shuffled_minimal_standard_prng_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the shuffled minimal standard generator.
// Each macro expects signals named clk and rst_n in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef SHUFFLED_MINIMAL_STANDARD_PRNG_ASSERT_SVH
`define SHUFFLED_MINIMAL_STANDARD_PRNG_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SMPR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SMPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMPR_ASSERT_IMPL(name, ante, cons, msg)
`define SMPR_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> rtl/smpr_pkg.sv
// ---------------------------------------------------------------------------
// smpr_pkg
// Constants, microcode types and the microcode program of the shuffled
// minimal standard generator.
// ---------------------------------------------------------------------------
package smpr_pkg;

  localparam int          TABLE_SIZE_DEF = 32;
  localparam int          WARM_EXTRA     = 8;
  localparam logic [14:0] LEHMER_MUL     = 15'd16807;
  localparam logic [30:0] LEHMER_MOD     = 31'h7FFF_FFFF;
  localparam logic [30:0] FRAC_CAP       = 31'd2147483389;
  localparam logic [30:0] SEED_MAX       = 31'h7FFF_FFFE;

  // Microcode addresses. The warm-up loop falls through into the draw.
  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_W_MUL = 3'd1,
    STEP_W_RED = 3'd2,
    STEP_D_MUL = 3'd3,
    STEP_D_RED = 3'd4,
    STEP_D_WR  = 3'd5,
    STEP_D_OUT = 3'd6
  } smpr_step_t;

  typedef enum logic [1:0] {
    COND_NEXT  = 2'd0,
    COND_START = 2'd1,
    COND_LOOP  = 2'd2,
    COND_JUMP  = 2'd3
  } smpr_cond_t;

  typedef struct packed {
    logic       mul_en;   // product <= state * multiplier
    logic       red_en;   // state <= product reduced modulo 2^31-1
    logic       warm_wr;  // table fill during warm-up
    logic       rd_en;    // read the selected slot
    logic       draw_wr;  // replace the selected slot, capture its value
    logic       out_en;   // finish the scaling and present the result
    smpr_cond_t cond;
    smpr_step_t target;
  } smpr_uop_t;

  typedef struct packed {
    logic      accept;
    logic      reseed;
    logic      warm_go;
    smpr_uop_t uop;
  } smpr_ctrl_t;

  typedef struct packed {
    logic last_zero;
    logic cnt_zero;
  } smpr_stat_t;

  // The control store.
  function automatic smpr_uop_t smpr_ucode(input smpr_step_t step);
    smpr_uop_t u;
    u = '0;
    unique case (step)
      STEP_IDLE:  begin
        u.cond = COND_START;
      end
      STEP_W_MUL: begin
        u.mul_en = 1'b1;
        u.cond   = COND_NEXT;
      end
      STEP_W_RED: begin
        u.red_en  = 1'b1;
        u.warm_wr = 1'b1;
        u.cond    = COND_LOOP;
        u.target  = STEP_W_MUL;
      end
      STEP_D_MUL: begin
        u.mul_en = 1'b1;
        u.cond   = COND_NEXT;
      end
      STEP_D_RED: begin
        u.red_en = 1'b1;
        u.rd_en  = 1'b1;
        u.cond   = COND_NEXT;
      end
      STEP_D_WR:  begin
        u.draw_wr = 1'b1;
        u.cond    = COND_NEXT;
      end
      STEP_D_OUT: begin
        u.out_en = 1'b1;
        u.cond   = COND_JUMP;
        u.target = STEP_IDLE;
      end
      default:    begin
        u.cond   = COND_JUMP;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

>>> rtl/smpr_ram.sv
// ---------------------------------------------------------------------------
// smpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module smpr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/smpr_seq.sv
// ---------------------------------------------------------------------------
// smpr_seq
// Microcode sequencer: step counter, control store and branch logic.
// ---------------------------------------------------------------------------
`include "shuffled_minimal_standard_prng_assert.svh"
module smpr_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_command,
  input  smpr_pkg::smpr_stat_t  stat,
  output logic                  busy,
  output smpr_pkg::smpr_ctrl_t  ctrl
);

  smpr_pkg::smpr_step_t pc_r, pc_nxt;
  smpr_pkg::smpr_uop_t  uop;
  logic                 accept;
  logic                 warm_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= smpr_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uop     = smpr_pkg::smpr_ucode(pc_r);
    accept  = (pc_r == smpr_pkg::STEP_IDLE) && start;
    warm_go = in_command || stat.last_zero;
    pc_nxt  = pc_r;
    unique case (uop.cond)
      smpr_pkg::COND_NEXT:  pc_nxt = smpr_pkg::smpr_step_t'(pc_r + 3'd1);
      smpr_pkg::COND_START: begin
        if (accept) begin
          pc_nxt = warm_go ? smpr_pkg::STEP_W_MUL : smpr_pkg::STEP_D_MUL;
        end
      end
      // The loop counter is tested before it is decremented in the same step.
      smpr_pkg::COND_LOOP:  begin
        pc_nxt = stat.cnt_zero ? smpr_pkg::smpr_step_t'(pc_r + 3'd1) : uop.target;
      end
      smpr_pkg::COND_JUMP:  pc_nxt = uop.target;
      default:              pc_nxt = smpr_pkg::STEP_IDLE;
    endcase
  end

  assign busy         = (pc_r != smpr_pkg::STEP_IDLE);
  assign ctrl.accept  = accept;
  assign ctrl.reseed  = accept && in_command;
  assign ctrl.warm_go = accept && warm_go;
  assign ctrl.uop     = uop;

  `SMPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
                    "Accepted transfer did not start the program.")
  `SMPR_ASSERT_NEXT(a_warm_exit, (pc_r == smpr_pkg::STEP_W_RED) && stat.cnt_zero,
                    pc_r == smpr_pkg::STEP_D_MUL, "Warm-up did not fall into the draw.")

endmodule

>>> rtl/smpr_dp.sv
// ---------------------------------------------------------------------------
// smpr_dp
// Datapath: Lehmer step, slot choice, shuffle table and range scaling.
// ---------------------------------------------------------------------------
`include "shuffled_minimal_standard_prng_assert.svh"
module smpr_dp #(
  parameter int TABLE_SIZE = smpr_pkg::TABLE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smpr_pkg::smpr_ctrl_t ctrl,
  input  logic [30:0]          in_new_seed,
  input  logic [15:0]          in_low_bound,
  input  logic [15:0]          in_high_bound,
  output smpr_pkg::smpr_stat_t stat,
  output logic                 out_valid,
  output logic [30:0]          out_random_value,
  output logic [15:0]          out_scaled_value,
  output logic                 out_warm_up_done
);

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int CNTW   = $clog2(TABLE_SIZE + smpr_pkg::WARM_EXTRA);
  localparam int CW     = $clog2(TABLE_SIZE + 1);
  localparam int PW     = 31 + CW;
  localparam logic [CNTW-1:0] CNT_START = CNTW'(TABLE_SIZE + smpr_pkg::WARM_EXTRA - 1);
  localparam logic [CNTW-1:0] CNT_FILL  = CNTW'(TABLE_SIZE);

  logic [30:0]     x_r, x_nxt;
  logic [30:0]     last_r, last_nxt;
  logic [45:0]     prod_r;
  logic [CNTW-1:0] cnt_r;
  logic [AW-1:0]   slot_r;
  logic [15:0]     lo_r, hi_r;
  logic            warm_r;
  logic [46:0]     sprod_r;
  logic            out_valid_r;
  logic [30:0]     value_r;
  logic [15:0]     scaled_r;
  logic            warm_out_r;

  logic [31:0]     red_sum;
  logic [30:0]     red;
  logic [30:0]     seed_cl;
  logic [PW-1:0]   sl_prod;
  logic [CW-1:0]   sl_q0;
  logic [31:0]     sl_corr;
  logic [CW-1:0]   sl_q;
  logic [AW-1:0]   slot_nxt;
  logic            tbl_we;
  logic [AW-1:0]   tbl_waddr;
  logic [30:0]     tbl_wdata;
  logic [30:0]     tbl_rdata;
  logic [30:0]     frac;
  logic [15:0]     span;
  logic [15:0]     part_q;
  logic [31:0]     part_r;
  logic [15:0]     part;

  // Modulo 2^31-1 by folding the high bits back onto the low bits.
  always_comb begin
    red_sum = 32'(prod_r[30:0]) + 32'(prod_r[45:31]);
    red     = (red_sum >= 32'(smpr_pkg::LEHMER_MOD)) ?
              31'(red_sum - 32'(smpr_pkg::LEHMER_MOD)) : red_sum[30:0];
  end

  always_comb begin
    if (in_new_seed == '0) begin
      seed_cl = 31'd1;
    end else if (in_new_seed == smpr_pkg::LEHMER_MOD) begin
      seed_cl = smpr_pkg::SEED_MAX;
    end else begin
      seed_cl = in_new_seed;
    end
  end

  // The divisor is 2^31 plus (TABLE_SIZE - 2), so the shifted quotient is
  // either exact or one too large; a narrow compare settles which.
  always_comb begin
    sl_prod  = PW'(last_r) * PW'(TABLE_SIZE);
    sl_q0    = sl_prod[PW-1:31];
    sl_corr  = 32'(sl_q0) * 32'(TABLE_SIZE - 2);
    sl_q     = (sl_corr > 32'(sl_prod[30:0])) ? CW'(sl_q0 - CW'(1)) : sl_q0;
    slot_nxt = sl_q[AW-1:0];
  end

  always_comb begin
    x_nxt    = x_r;
    last_nxt = last_r;
    if (ctrl.reseed) begin
      x_nxt = seed_cl;
    end else if (ctrl.uop.red_en) begin
      x_nxt = red;
    end
    if (ctrl.uop.warm_wr && (cnt_r == '0)) begin
      last_nxt = red;
    end else if (ctrl.uop.draw_wr) begin
      last_nxt = tbl_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= 31'd1;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      last_r      <= last_nxt;
      out_valid_r <= ctrl.uop.out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      lo_r   <= in_low_bound;
      hi_r   <= in_high_bound;
      warm_r <= ctrl.warm_go;
      cnt_r  <= CNT_START;
    end
    if (ctrl.uop.mul_en) begin
      prod_r <= 46'(x_r) * 46'(smpr_pkg::LEHMER_MUL);
    end
    if (ctrl.uop.warm_wr) begin
      cnt_r <= CNTW'(cnt_r - CNTW'(1));
    end
    if (ctrl.uop.rd_en) begin
      slot_r <= slot_nxt;
    end
    if (ctrl.uop.draw_wr) begin
      value_r <= tbl_rdata;
      sprod_r <= 47'(span) * 47'(frac);
    end
    if (ctrl.uop.out_en) begin
      scaled_r   <= (hi_r >= lo_r) ? 16'(lo_r + part) : 16'(lo_r - part);
      warm_out_r <= warm_r;
    end
  end

  always_comb begin
    tbl_we    = (ctrl.uop.warm_wr && (cnt_r < CNT_FILL)) || ctrl.uop.draw_wr;
    tbl_waddr = ctrl.uop.draw_wr ? slot_r : cnt_r[AW-1:0];
    tbl_wdata = ctrl.uop.draw_wr ? x_r : red;
  end

  smpr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (ctrl.uop.rd_en),
    .raddr (slot_nxt),
    .rdata (tbl_rdata)
  );

  // Scaling: the product divided by 2^31-1, again by folding.
  always_comb begin
    frac   = (tbl_rdata > smpr_pkg::FRAC_CAP) ? smpr_pkg::FRAC_CAP : tbl_rdata;
    span   = (hi_r >= lo_r) ? 16'(hi_r - lo_r) : 16'(lo_r - hi_r);
    part_q = sprod_r[46:31];
    part_r = 32'(sprod_r[30:0]) + 32'(part_q);
    part   = 16'(part_q + 16'(part_r >= 32'(smpr_pkg::LEHMER_MOD)));
  end

  assign stat.last_zero   = (last_r == '0);
  assign stat.cnt_zero    = (cnt_r == '0);
  assign out_valid        = out_valid_r;
  assign out_random_value = value_r;
  assign out_scaled_value = scaled_r;
  assign out_warm_up_done = warm_out_r;

  `SMPR_ASSERT_IMPL(a_state_nonzero, 1'b1, x_r != '0, "Generator state reached zero.")
  `SMPR_ASSERT_IMPL(a_slot_range, ctrl.uop.rd_en, 32'(slot_nxt) < 32'(TABLE_SIZE),
                    "Chosen slot lies beyond the table.")
  `SMPR_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r,
                    "Result strobe lasted more than one cycle.")

endmodule

>>> rtl/shuffled_minimal_standard_prng.sv
// ---------------------------------------------------------------------------
// shuffled_minimal_standard_prng
// Minimal standard Lehmer generator with a Bays-Durham shuffle table.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with in_command, in_new_seed and the bounds; the transfer
//   takes place at a clock edge where start is high and busy is low.
//   in_command 0 draws the next value, 1 reseeds and then draws. A draw
//   before any seeding also runs the warm-up from the reset state.
//   Each transfer yields exactly one result, shown for a single cycle with
//   out_valid high; the receiver cannot stall it and must take it then.
//   A plain draw runs the steps D_MUL, D_RED, D_WR and D_OUT; its result
//   appears in the same cycle that busy falls, and no new transfer is taken
//   until busy has fallen. A warm-up runs TABLE_SIZE + 8 generator steps,
//   each a multiply and a reduce on the shared multiplier and reducer,
//   before the draw. The table has one write and one read port, which sets
//   the four-step draw program.
//   Reset returns the sequencer to idle, sets the generator state to one
//   and marks the block unseeded; the table contents are left as they are.
// ---------------------------------------------------------------------------
module shuffled_minimal_standard_prng #(
  parameter int TABLE_SIZE = smpr_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [30:0] in_new_seed,
  input  logic [15:0] in_low_bound,
  input  logic [15:0] in_high_bound,
  output logic        out_valid,
  output logic [30:0] out_random_value,
  output logic [15:0] out_scaled_value,
  output logic        out_warm_up_done
);

  smpr_pkg::smpr_ctrl_t ctrl;
  smpr_pkg::smpr_stat_t stat;

  smpr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .busy       (busy),
    .ctrl       (ctrl)
  );

  smpr_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_new_seed      (in_new_seed),
    .in_low_bound     (in_low_bound),
    .in_high_bound    (in_high_bound),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_random_value (out_random_value),
    .out_scaled_value (out_scaled_value),
    .out_warm_up_done (out_warm_up_done)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for shuffled_minimal_standard_prng
// Drives draw and reseed commands through the start/busy handshake, keeps a
// software copy of the Lehmer generator and its shuffle table, and compares
// every strobed result field by field with the predicted draw.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int     SLOTS        = smpr_pkg::TABLE_SIZE_DEF;
  localparam int     WARM_STEPS   = SLOTS + smpr_pkg::WARM_EXTRA;
  localparam longint MODULUS      = 64'(smpr_pkg::LEHMER_MOD);
  localparam longint MULT         = 64'(smpr_pkg::LEHMER_MUL);
  localparam longint CAP          = 64'(smpr_pkg::FRAC_CAP);
  localparam int     RANDOM_ITEMS = 1800;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     DRAIN_CYCLES = 2 * WARM_STEPS + 20;
  localparam int     MAX_REPORTS  = 10;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct {
    logic [30:0] random_value;
    logic [15:0] scaled_value;
    logic        warm_up_done;
  } draw_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        in_command    = 1'b0;
  logic [30:0] in_new_seed   = '0;
  logic [15:0] in_low_bound  = '0;
  logic [15:0] in_high_bound = '0;
  logic        busy;
  logic        out_valid;
  logic [30:0] out_random_value;
  logic [15:0] out_scaled_value;
  logic        out_warm_up_done;

  // Software copy of the generator.
  logic [30:0] gen_state  = 31'd1;
  logic [30:0] shuffle_tab [SLOTS];
  logic [30:0] last_value = '0;

  draw_t pending_draws[$];

  int     n_items       = 0;
  int     n_reseeds     = 0;
  int     n_swapped     = 0;
  int     n_results     = 0;
  int     n_warm_seen   = 0;
  int     n_errors      = 0;
  longint cycle_count   = 0;
  int     burst_left    = 0;
  bit     idle_on       = 1'b1;

  shuffled_minimal_standard_prng u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_new_seed      (in_new_seed),
    .in_low_bound     (in_low_bound),
    .in_high_bound    (in_high_bound),
    .out_valid        (out_valid),
    .out_random_value (out_random_value),
    .out_scaled_value (out_scaled_value),
    .out_warm_up_done (out_warm_up_done)
  );

  always #1 clk = ~clk;

  function automatic longint mul_mod(longint a, longint b);
    return (a * b) % MODULUS;
  endfunction

  function automatic longint pow_mod(longint b, longint e);
    longint r;
    r = 1;
    while (e > 0) begin
      if (e[0]) r = mul_mod(r, b);
      b = mul_mod(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [30:0] lehmer_next(logic [30:0] x);
    return 31'(mul_mod(64'(x), MULT));
  endfunction

  function automatic logic [15:0] scale_to_range(logic [30:0] v, logic [15:0] lo,
                                                 logic [15:0] hi);
    longint f;
    longint part;
    f = 64'(v);
    if (f > CAP) f = CAP;
    if (hi >= lo) begin
      part = (64'(hi) - 64'(lo)) * f / MODULUS;
      return 16'(64'(lo) + part);
    end
    part = (64'(lo) - 64'(hi)) * f / MODULUS;
    return 16'(64'(lo) - part);
  endfunction

  // Advances the software generator by one accepted item and returns the draw.
  function automatic draw_t predict_draw(logic cmd, logic [30:0] seed, logic [15:0] lo,
                                         logic [15:0] hi);
    draw_t       d;
    logic [30:0] s;
    int          slot;
    logic        warm;
    warm = 1'b0;
    if (cmd == CMD_RESEED) begin
      s = seed;
      if (s == '0) s = 31'd1;
      if (s > smpr_pkg::SEED_MAX) s = smpr_pkg::SEED_MAX;
      gen_state = s;
    end
    if (cmd == CMD_RESEED || last_value == '0) begin
      // The first eight steps are discarded; the rest fill the table top down.
      for (int i = WARM_STEPS - 1; i >= 0; i--) begin
        gen_state = lehmer_next(gen_state);
        if (i < SLOTS) shuffle_tab[i] = gen_state;
      end
      last_value = shuffle_tab[0];
      warm       = 1'b1;
    end
    gen_state = lehmer_next(gen_state);
    slot = int'((64'(last_value) * SLOTS) / (SLOTS + MODULUS - 1));
    if (slot >= SLOTS) slot = SLOTS - 1;
    d.random_value    = shuffle_tab[slot];
    shuffle_tab[slot] = gen_state;
    last_value        = d.random_value;
    d.scaled_value    = scale_to_range(d.random_value, lo, hi);
    d.warm_up_done    = warm;
    return d;
  endfunction

  // Finds a seed whose first draw after reseeding returns the given value, or 0.
  // The draw returns the entry written at step 40 - slot, where the slot is
  // chosen from the value of step 40.
  function automatic longint seed_for_first_draw(longint target);
    longint inv;
    longint x;
    inv = pow_mod(MULT, MODULUS - 2);
    x   = target;
    for (int slot = 0; slot < SLOTS; slot++) begin
      if ((x * SLOTS) / (SLOTS + MODULUS - 1) == slot)
        return mul_mod(target, pow_mod(inv, WARM_STEPS - slot));
      x = mul_mod(x, MULT);
    end
    return 0;
  endfunction

  task automatic note_mismatch(string what, longint expected, longint actual);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, what, expected, actual);
  endtask

  // One transfer, followed by the sender's idle pattern.
  task automatic send_item(logic cmd, logic [30:0] seed, logic [15:0] lo, logic [15:0] hi);
    int    gap;
    draw_t predicted;
    start         <= 1'b1;
    in_command    <= cmd;
    in_new_seed   <= seed;
    in_low_bound  <= lo;
    in_high_bound <= hi;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_draw(cmd, seed, lo, hi);
    pending_draws.insert(pending_draws.size(), predicted);
    n_items++;
    if (cmd == CMD_RESEED) n_reseeds++;
    if (hi < lo) n_swapped++;
    gap = 0;
    if (idle_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_unseeded_draw();
    send_item(CMD_DRAW, 31'd12345, 16'd0, 16'd65535);
    send_item(CMD_DRAW, 31'd0, 16'd0, 16'd65535);
  endtask

  task automatic test_seed_clamp();
    send_item(CMD_RESEED, 31'd0, 16'd0, 16'd65535);
    send_item(CMD_RESEED, smpr_pkg::LEHMER_MOD, 16'd0, 16'd65535);
    send_item(CMD_RESEED, 31'd1, 16'd0, 16'd65535);
    send_item(CMD_RESEED, smpr_pkg::SEED_MAX, 16'd0, 16'd65535);
  endtask

  task automatic test_bound_extremes();
    send_item(CMD_DRAW, 31'd0, 16'd65535, 16'd0);
    send_item(CMD_DRAW, 31'd0, 16'd0, 16'd0);
    send_item(CMD_DRAW, 31'd0, 16'd65535, 16'd65535);
    send_item(CMD_DRAW, 31'd0, 16'd4660, 16'd4660);
    send_item(CMD_DRAW, 31'd0, 16'd40000, 16'd39999);
    send_item(CMD_DRAW, 31'd0, 16'd1, 16'd65534);
  endtask

  // Reseeds so that the very next result lands near the top of the range.
  task automatic draw_near_top(longint from, longint step);
    longint v;
    longint seed;
    v    = from;
    seed = seed_for_first_draw(v);
    while (seed == 0) begin
      v    = v + step;
      seed = seed_for_first_draw(v);
    end
    send_item(CMD_RESEED, 31'(seed), 16'd0, 16'd65535);
    send_item(CMD_DRAW, 31'd0, 16'd65535, 16'd0);
  endtask

  task automatic test_fraction_cap();
    draw_near_top(MODULUS - 1, -1);
    draw_near_top(CAP + 1, 1);
    draw_near_top(CAP, -1);
  endtask

  task automatic test_random_traffic();
    logic        cmd;
    logic [30:0] seed;
    logic [15:0] lo;
    logic [15:0] hi;
    int          pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Every third stretch of 300 items runs back to back.
      idle_on = ((n / 300) % 3) != 2;
      cmd  = ($urandom_range(0, 19) == 0) ? CMD_RESEED : CMD_DRAW;
      pick = $urandom_range(0, 9);
      seed = (pick == 0) ? 31'd0 : (pick == 1) ? smpr_pkg::LEHMER_MOD : 31'($urandom);
      pick = $urandom_range(0, 9);
      lo   = 16'($urandom);
      if (pick <= 5) begin
        hi = 16'($urandom_range(lo, 16'hFFFF));
      end else if (pick <= 7) begin
        hi = 16'($urandom);
      end else if (pick == 8) begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end else begin
        hi = lo;
      end
      send_item(cmd, seed, lo, hi);
    end
  endtask

  always @(posedge clk) begin
    draw_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_warm_up_done) n_warm_seen++;
      if (pending_draws.size() == 0) begin
        note_mismatch("result with no transfer pending, random_value", 0, out_random_value);
      end else begin
        e = pending_draws.pop_front();
        if (out_random_value !== e.random_value)
          note_mismatch("random_value", e.random_value, out_random_value);
        if (out_scaled_value !== e.scaled_value)
          note_mismatch("scaled_value", e.scaled_value, out_scaled_value);
        if (out_warm_up_done !== e.warm_up_done)
          note_mismatch("warm_up_done", e.warm_up_done, out_warm_up_done);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_draws.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_unseeded_draw();
    test_seed_clamp();
    test_bound_extremes();
    test_fraction_cap();
    test_random_traffic();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d transfers (%0d reseeds, %0d with high below low), %0d results",
             n_items, n_reseeds, n_swapped, n_results);
    $display("summary: %0d warm-ups seen, %0d mismatches, %0d cycles",
             n_warm_seen, n_errors, cycle_count);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
